>>> src/b2da_pkg.sv
// shared types, constants and helpers for the binary to decimal ascii unit
package b2da_pkg;

  localparam int ValueWidthDef = 16;
  localparam int DigitCount    = 5;
  localparam int NumW          = 17;
  localparam int PosW          = 3;

  typedef logic [NumW-1:0] num_t;
  typedef logic [PosW-1:0] pos_t;
  typedef logic [3:0]      digit_t;
  typedef logic [5:0]      char_t;

  localparam num_t   DigitLimit = num_t'(99999);
  localparam char_t  AsciiZero  = char_t'(48);
  localparam char_t  AsciiNine  = char_t'(57);
  localparam pos_t   FirstPos   = pos_t'(0);
  localparam pos_t   LastPos    = pos_t'(DigitCount - 1);
  localparam int     Radix      = 10;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic last_pos;
    pos_t pos;
  } b2da_cmd_t;

  // weight of a decimal position, most significant first
  function automatic num_t pos_weight(input pos_t pos);
    num_t w;
    w = num_t'(1);
    unique case (pos)
      3'd0:    w = num_t'(10000);
      3'd1:    w = num_t'(1000);
      3'd2:    w = num_t'(100);
      3'd3:    w = num_t'(Radix);
      default: w = num_t'(1);
    endcase
    return w;
  endfunction

endpackage

>>> src/b2da_ctrl.sv
// controller: walks the five decimal positions of one number
module b2da_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output b2da_pkg::b2da_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic            state_r, state_nxt;
  b2da_pkg::pos_t  pos_r, pos_nxt;
  logic            at_last;
  logic            load;

  assign at_last = (pos_r == b2da_pkg::LastPos);
  // the next number may enter during the final position step
  assign busy    = (state_r == ST_RUN) && !at_last;
  assign load    = start && !busy;

  assign cmd.load     = load;
  assign cmd.step     = (state_r == ST_RUN);
  assign cmd.last_pos = at_last;
  assign cmd.pos      = pos_r;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          state_nxt = ST_RUN;
          pos_nxt   = b2da_pkg::FirstPos;
        end
      end
      ST_RUN: begin
        if (load) begin
          pos_nxt = b2da_pkg::FirstPos;
        end else if (at_last) begin
          state_nxt = ST_IDLE;
        end else begin
          pos_nxt = pos_r + b2da_pkg::pos_t'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= b2da_pkg::FirstPos;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> pos_r <= b2da_pkg::LastPos)
    else $error("position counter out of range");

  a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (state_r == ST_RUN && pos_r == b2da_pkg::FirstPos))
    else $error("accepted item did not start at the top position");

endmodule

>>> src/b2da_dpath.sv
// datapath: remainder register, digit select by multiple compare, output register
module b2da_dpath #(
  parameter int VALUE_WIDTH = b2da_pkg::ValueWidthDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  b2da_pkg::b2da_cmd_t     cmd,
  input  logic [VALUE_WIDTH-1:0]  in_value,
  output logic                    out_valid,
  output logic [5:0]              out_digit_char,
  output logic                    out_last
);

  localparam int ExtW = (VALUE_WIDTH > b2da_pkg::NumW) ? VALUE_WIDTH : b2da_pkg::NumW;

  b2da_pkg::num_t    val_r, val_nxt;
  logic              started_r, started_nxt;
  logic              out_valid_r, out_last_r;
  b2da_pkg::char_t   out_char_r;
  logic [ExtW-1:0]   in_ext;
  b2da_pkg::num_t    in_sat;
  b2da_pkg::num_t    weight;
  b2da_pkg::num_t    msel;
  b2da_pkg::num_t    rem;
  b2da_pkg::digit_t  digit;
  logic              emit;

  // saturate to five digits
  assign in_ext = ExtW'(in_value);
  assign in_sat = (in_ext > ExtW'(b2da_pkg::DigitLimit)) ? b2da_pkg::DigitLimit
                                                         : b2da_pkg::num_t'(in_ext);

  assign weight = b2da_pkg::pos_weight(cmd.pos);

  // remainder is below ten times the weight: largest multiple not above it
  always_comb begin
    digit = '0;
    msel  = '0;
    for (int j = 1; j < b2da_pkg::Radix; j++) begin
      if (val_r >= b2da_pkg::num_t'(weight * b2da_pkg::num_t'(j))) begin
        digit = b2da_pkg::digit_t'(j);
        msel  = b2da_pkg::num_t'(weight * b2da_pkg::num_t'(j));
      end
    end
    rem = val_r - msel;
  end

  // leading zeros are dropped, the units digit always goes out
  assign emit = cmd.step && (started_r || cmd.last_pos || (digit != '0));

  always_comb begin
    val_nxt     = val_r;
    started_nxt = started_r;
    if (cmd.load) begin
      val_nxt     = in_sat;
      started_nxt = 1'b0;
    end else if (cmd.step) begin
      val_nxt     = rem;
      started_nxt = started_r || emit;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    out_char_r <= b2da_pkg::AsciiZero + b2da_pkg::char_t'(digit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      out_valid_r <= emit;
      out_last_r  <= emit && cmd.last_pos;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r >= b2da_pkg::AsciiZero && out_char_r <= b2da_pkg::AsciiNine))
    else $error("digit character outside '0' to '9'");

  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_valid_r)
    else $error("last flag without a strobe");

endmodule

>>> src/binary_to_decimal_ascii_unit.sv
// top level: unsigned binary to decimal ascii digit stream
//
// Each item on in_value (start high while busy is low) is turned into its
// decimal text, most significant digit first, one ASCII character '0'..'9'
// per out_valid strobe, with out_last on the units digit. Leading zeros are
// dropped and zero gives a single '0'; values above 99999 (only possible
// with VALUE_WIDTH above 16) are clamped to 99999. The unit scans the five
// decimal positions of each number one per cycle, whatever its digit count; a
// new item is taken in the cycle of the last position, so back-to-back items
// follow with no gap between scans. Each strobe lasts one cycle and
// cannot be held off: the receiver must take every strobed character. The
// first character of a number is registered once the scan reaches its leading
// digit and is taken at the edge that ends the cycle it is on the ports.
module binary_to_decimal_ascii_unit #(
  parameter int VALUE_WIDTH = b2da_pkg::ValueWidthDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  output logic [5:0]             out_digit_char,
  output logic                   out_last
);

  // command bundle from sequencer to digit datapath
  b2da_pkg::b2da_cmd_t cmd;

  // position sequencer and input handshake
  b2da_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // remainder register, digit select and registered character output
  b2da_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the binary to decimal ascii unit
`timescale 1ns / 100ps

module tb_top;

  localparam int ValueW     = b2da_pkg::ValueWidthDef;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 20;

  // one decimal character as the unit should strobe it
  typedef struct packed {
    b2da_pkg::char_t digit_char;
    logic            last;
  } digit_exp_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [ValueW-1:0] in_value;
  logic              out_valid;
  logic [5:0]        out_digit_char;
  logic              out_last;

  digit_exp_t pending_digits[$];
  int         numbers_sent;
  int         digits_checked;
  int         error_count;
  int         cycle_count;

  binary_to_decimal_ascii_unit #(
    .VALUE_WIDTH(ValueW)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_digit_char(out_digit_char),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  // decimal text of one number, most significant digit first, last flag on units
  function automatic void predict_digits(input logic [ValueW-1:0] value);
    longint unsigned  n;
    b2da_pkg::digit_t dec [b2da_pkg::DigitCount];
    int               cnt;
    digit_exp_t       e;
    n   = 64'(value);
    cnt = 0;
    // clamp so no number needs more than five characters
    if (n > 99999) begin
      n = 99999;
    end
    do begin
      dec[cnt] = b2da_pkg::digit_t'(n % 10);
      n        = n / 10;
      cnt++;
    end while (n != 0 && cnt < b2da_pkg::DigitCount);
    for (int k = 0; k < cnt; k++) begin
      e.digit_char = b2da_pkg::AsciiZero + b2da_pkg::char_t'(dec[cnt-1-k]);
      e.last       = (k == cnt - 1);
      pending_digits.push_back(e);
    end
  endfunction

  // number whose digit count is spread evenly, now and then any 16-bit value
  function automatic logic [ValueW-1:0] random_number();
    int unsigned nd;
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(3, 0) == 0) begin
      return ValueW'($urandom_range(65535, 0));
    end
    nd = $urandom_range(5, 1);
    lo = (nd == 1) ? 0 : 10 ** (nd - 1);
    hi = 10 ** nd - 1;
    if (hi > 65535) begin
      hi = 65535;
    end
    return ValueW'($urandom_range(hi, lo));
  endfunction

  // present one item from the falling edge until an edge with busy low takes it
  task automatic send_number(input logic [ValueW-1:0] value);
    @(negedge clk);
    start    <= 1'b1;
    in_value <= value;
    do begin
      @(posedge clk);
    end while (busy);
    predict_digits(value);
    numbers_sent++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start    <= 1'b0;
      in_value <= ValueW'($urandom_range(65535, 0));
    end
  endtask

  // zero, every digit-count boundary, all-ones and alternating bit patterns
  task automatic test_digit_boundaries();
    int unsigned vals [$];
    vals = '{0, 1, 9, 10, 11, 99, 100, 999, 1000, 9999, 10000, 10001, 12345,
             54321, 20000, 50005, 60606, 32768, 43690, 21845, 65534, 65535};
    foreach (vals[i]) begin
      send_number(ValueW'(vals[i]));
      idle_cycles($urandom_range(3, 0));
    end
  endtask

  // start held high so items follow each other as fast as the unit allows
  task automatic test_back_to_back(input int n);
    repeat (n) begin
      send_number(random_number());
    end
    idle_cycles(1);
  endtask

  // bursts of random length with random gaps, some bursts without gaps
  task automatic test_random_bursts(input int n);
    int left;
    int burst;
    bit gapless;
    left = n;
    while (left > 0) begin
      burst   = $urandom_range(12, 1);
      gapless = ($urandom_range(3, 0) == 0);
      if (burst > left) begin
        burst = left;
      end
      repeat (burst) begin
        send_number(random_number());
        if (!gapless && $urandom_range(2, 0) == 0) begin
          idle_cycles($urandom_range(6, 1));
        end
      end
      left -= burst;
      idle_cycles($urandom_range(15, 1));
    end
  endtask

  // each strobed character is compared with the oldest expected one
  always @(posedge clk) begin
    digit_exp_t e;
    if (rst_n && out_valid) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected character: digit_char %0d last %0b", out_digit_char, out_last);
        error_count++;
      end else begin
        e = pending_digits.pop_front();
        digits_checked++;
        if (out_digit_char !== e.digit_char) begin
          $error("digit_char mismatch: expected %0d, got %0d", e.digit_char, out_digit_char);
          error_count++;
        end
        if (out_last !== e.last) begin
          $error("last mismatch: expected %0b, got %0b", e.last, out_last);
          error_count++;
        end
      end
    end
  end

  // watchdog for a hung handshake or missing characters
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d characters outstanding",
               cycle_count, pending_digits.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_value       = '0;
    numbers_sent   = 0;
    digits_checked = 0;
    error_count    = 0;
    cycle_count    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_digit_boundaries();
    test_back_to_back(30);
    test_random_bursts(450);
    idle_cycles(1);

    // drain, then give a stray extra character time to show up
    while (pending_digits.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainWait) @(posedge clk);

    $display("converted %0d numbers, %0d digit characters checked, %0d mismatches",
             numbers_sent, digits_checked, error_count);
    $display("covered zero, every digit-count boundary, full 16-bit range, gapless runs");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
